// ===== sv/dzp_pkg.sv =====
// shared types and constants for the delta zigzag packed decoder
// no dependencies; imported by every module of the decoder
`default_nettype none

package dzp_pkg;

    localparam int CMD_DEPTH_DEF = 4;

    localparam int BLEN_W   = 24;
    localparam int SAMPLE_W = 32;
    localparam int SHIFT_W  = 6;

    localparam logic [BLEN_W-1:0]  BLOCK_LENGTH_RST = 24'd1;
    localparam logic [7:0]         CONT_MASK        = 8'h80;
    localparam logic [SHIFT_W-1:0] LONG_HEAD_BITS   = 6'd6;
    localparam logic [SHIFT_W-1:0] LONG_STEP_BITS   = 6'd7;
    localparam logic [SHIFT_W-1:0] LONG_SHIFT_LIMIT = 6'd32;

    typedef enum logic [1:0] {
        ST_SAMPLE  = 2'd0,
        ST_ERROR   = 2'd1,
        ST_IGNORED = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        FORM_TRIPLE = 2'b00,
        FORM_PAIR   = 2'b01,
        FORM_SINGLE = 2'b10,
        FORM_LONG   = 2'b11
    } form_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       block_start;
    } in_word_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [1:0]                 status;
        logic                       last_of_byte;
        logic                       block_done;
    } out_word_t;

    // one classified byte: up to three codes for the back end
    typedef struct packed {
        logic                clr;
        status_t             status;
        logic [1:0]          count;
        logic [SAMPLE_W-1:0] code0;
        logic [2:0]          code1;
        logic [1:0]          code2;
        logic                done;
    } cmd_t;

    function automatic logic [SAMPLE_W-1:0] zigzag(input logic [SAMPLE_W-1:0] code);
        logic [SAMPLE_W-1:0] half;
        half = code >> 1;
        return code[0] ? ~half : half;
    endfunction

endpackage

`default_nettype wire

// ===== sv/dzp_front.sv =====
// front end: takes bytes, tracks block count and long codes, emits commands
// depends on dzp_pkg
`default_nettype none

module dzp_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire dzp_pkg::in_word_t in_word,
    input  wire logic             cfg_write,
    input  wire logic [23:0]      cfg_data,
    output logic                  cmd_push,
    output dzp_pkg::cmd_t         cmd
);
    import dzp_pkg::*;

    logic [BLEN_W-1:0]   block_length_reg;
    logic [BLEN_W-1:0]   remaining_reg, remaining_next;
    logic                halted_reg, halted_next;
    logic                in_long_reg, in_long_next;
    logic [SAMPLE_W-1:0] acc_reg, acc_next;
    logic [SHIFT_W-1:0]  shift_reg, shift_next;
    logic                pend_clr_reg, pend_clr_next;

    logic [BLEN_W-1:0]   rem;
    logic [SAMPLE_W-1:0] part;
    logic [7:0]          b;
    logic                produce;
    logic                bs;

    always_comb
    begin
        b  = in_word.data_byte;
        bs = in_word.block_start;

        rem            = bs ? block_length_reg : remaining_reg;
        remaining_next = rem;
        halted_next    = bs ? 1'b0 : halted_reg;
        in_long_next   = bs ? 1'b0 : in_long_reg;
        acc_next       = bs ? '0 : acc_reg;
        shift_next     = bs ? '0 : shift_reg;

        part    = {{(SAMPLE_W-7){1'b0}}, b[6:0]} << shift_next[4:0];
        produce = 1'b0;

        cmd        = '0;
        cmd.status = ST_SAMPLE;
        cmd.count  = 2'd1;
        cmd.clr    = bs | pend_clr_reg;

        if (in_long_next)
        begin
            if (shift_next < LONG_SHIFT_LIMIT)
            begin
                acc_next   = acc_next + part;
                shift_next = shift_next + LONG_STEP_BITS;
            end
            if ((b & CONT_MASK) == '0)
            begin
                in_long_next = 1'b0;
                produce      = 1'b1;
                cmd.code0    = acc_next;
                cmd.done     = (rem <= BLEN_W'(1));
                if (rem != '0)
                    remaining_next = rem - BLEN_W'(1);
            end
        end
        else if (halted_next || rem == '0)
        begin
            produce    = 1'b1;
            cmd.status = ST_IGNORED;
        end
        else
        begin
            case (form_t'(b[7:6]))
                FORM_TRIPLE:
                begin
                    produce = 1'b1;
                    if (rem < BLEN_W'(3))
                    begin
                        halted_next = 1'b1;
                        cmd.status  = ST_ERROR;
                    end
                    else
                    begin
                        cmd.count      = 2'd3;
                        cmd.code0      = {{(SAMPLE_W-2){1'b0}}, b[1:0]};
                        cmd.code1      = {1'b0, b[3:2]};
                        cmd.code2      = b[5:4];
                        cmd.done       = (rem == BLEN_W'(3));
                        remaining_next = rem - BLEN_W'(3);
                    end
                end
                FORM_PAIR:
                begin
                    produce = 1'b1;
                    if (rem < BLEN_W'(2))
                    begin
                        halted_next = 1'b1;
                        cmd.status  = ST_ERROR;
                    end
                    else
                    begin
                        cmd.count      = 2'd2;
                        cmd.code0      = {{(SAMPLE_W-3){1'b0}}, b[2:0]};
                        cmd.code1      = b[5:3];
                        cmd.done       = (rem == BLEN_W'(2));
                        remaining_next = rem - BLEN_W'(2);
                    end
                end
                FORM_SINGLE:
                begin
                    produce        = 1'b1;
                    cmd.code0      = {{(SAMPLE_W-6){1'b0}}, b[5:0]};
                    cmd.done       = (rem == BLEN_W'(1));
                    remaining_next = rem - BLEN_W'(1);
                end
                default:
                begin
                    // long code head, count is taken when it finishes
                    in_long_next = 1'b1;
                    acc_next     = {{(SAMPLE_W-6){1'b0}}, b[5:0]};
                    shift_next   = LONG_HEAD_BITS;
                end
            endcase
        end

        // a block start with no word of its own clears the predictor on the next one
        pend_clr_next = produce ? 1'b0 : (bs | pend_clr_reg);
        cmd_push      = accept & produce;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_length_reg <= BLOCK_LENGTH_RST;
            remaining_reg    <= '0;
            halted_reg       <= 1'b1;
            in_long_reg      <= 1'b0;
            acc_reg          <= '0;
            shift_reg        <= '0;
            pend_clr_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                block_length_reg <= cfg_data;
            if (accept)
            begin
                remaining_reg <= remaining_next;
                halted_reg    <= halted_next;
                in_long_reg   <= in_long_next;
                acc_reg       <= acc_next;
                shift_reg     <= shift_next;
                pend_clr_reg  <= pend_clr_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/dzp_cmd_queue.sv =====
// command queue between front and back end
// depends on dzp_pkg for the command type
`default_nettype none

module dzp_cmd_queue #(
    parameter int DEPTH = dzp_pkg::CMD_DEPTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire dzp_pkg::cmd_t wr_data,
    output logic               full,
    input  wire logic          rd_en,
    output dzp_pkg::cmd_t      rd_data,
    output logic               empty
);
    import dzp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        do_wr       = wr_en & ~full;
        do_rd       = rd_en & ~empty;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        count_next = count_reg + CNT_W'(do_wr) - CNT_W'(do_rd);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/dzp_back.sv =====
// back end: steps through the codes of a command, updates the predictor,
// and holds results in a two-word output queue; depends on dzp_pkg
`default_nettype none

module dzp_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire dzp_pkg::cmd_t cmd,
    input  wire logic          cmd_empty,
    output logic               cmd_pop,
    output dzp_pkg::out_word_t out_word,
    output logic               empty,
    input  wire logic          pop
);
    import dzp_pkg::*;

    logic [SAMPLE_W-1:0] pred_reg, pred_next;
    logic [1:0]          idx_reg, idx_next;
    out_word_t           ent_reg [2];
    logic                wr_ptr_reg, rd_ptr_reg;
    logic [1:0]          count_reg;

    logic                issue, last, do_pop;
    logic [SAMPLE_W-1:0] code, base;
    out_word_t           res;

    assign empty    = (count_reg == 2'd0);
    assign out_word = ent_reg[rd_ptr_reg];
    assign do_pop   = pop & ~empty;

    always_comb
    begin
        issue = ~cmd_empty & (count_reg != 2'd2);
        last  = (idx_reg == cmd.count - 2'd1);

        case (idx_reg)
            2'd0:    code = cmd.code0;
            2'd1:    code = {{(SAMPLE_W-3){1'b0}}, cmd.code1};
            default: code = {{(SAMPLE_W-2){1'b0}}, cmd.code2};
        endcase

        base = (cmd.clr && idx_reg == 2'd0) ? '0 : pred_reg;

        res              = '0;
        res.status       = cmd.status;
        res.last_of_byte = last;
        pred_next        = base;
        if (cmd.status == ST_SAMPLE)
        begin
            pred_next      = base + zigzag(code);
            res.sample     = pred_next;
            res.block_done = last & cmd.done;
        end

        idx_next = last ? 2'd0 : idx_reg + 2'd1;
        cmd_pop  = issue & last;
    end

    always_ff @(posedge clk)
    begin
        if (issue)
            ent_reg[wr_ptr_reg] <= res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pred_reg   <= '0;
            idx_reg    <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (issue)
            begin
                pred_reg   <= pred_next;
                idx_reg    <= idx_next;
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(issue) - 2'(do_pop);
        end
    end

endmodule

`default_nettype wire

// ===== sv/delta_zigzag_packed_decoder.sv =====
// Delta zigzag packed decoder: bytes in through push/full, one result word
// out per pop/empty. The front end takes one byte per cycle while the command
// queue is not full and turns it into a command of up to three codes; a
// command queue of CMD_DEPTH entries sits between it and the back end, which
// emits one result word per cycle while its two-word output queue has room,
// from a single 32-bit predictor adder. A byte giving n results (n = 1..3)
// holds the back end until all n are emitted, so the sustained rate is one
// byte per cycle only for single-result bytes; long-code bytes that give no
// result still take their turn at the front. With nothing queued ahead, the
// first result word of a byte passes through the command queue and then the
// output queue before it shows on the outputs. block_length takes effect at
// the next block start. Depends on dzp_pkg, dzp_front, dzp_cmd_queue, dzp_back.
`default_nettype none

module delta_zigzag_packed_decoder #(
    parameter int CMD_DEPTH = dzp_pkg::CMD_DEPTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire dzp_pkg::in_word_t in_word,
    output logic                   full,
    output dzp_pkg::out_word_t     out_word,
    output logic                   empty,
    input  wire logic              pop,
    input  wire logic              cfg_write,
    input  wire logic [23:0]       cfg_data
);
    import dzp_pkg::*;

    logic accept;
    logic cmd_push, cmd_full, cmd_empty, cmd_pop;
    cmd_t cmd_in, cmd_head;

    assign full   = cmd_full;
    assign accept = push & ~cmd_full;

    dzp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_word   (in_word),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .cmd_push  (cmd_push),
        .cmd       (cmd_in)
    );

    dzp_cmd_queue #(
        .DEPTH (CMD_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_in),
        .full    (cmd_full),
        .rd_en   (cmd_pop),
        .rd_data (cmd_head),
        .empty   (cmd_empty)
    );

    dzp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_head),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .out_word  (out_word),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

`default_nettype wire
